>>> hw/rtl/flat_json_string_object_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the JSON object tokenizer
// Immediate-consequence and next-cycle checks, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef FLAT_JSON_STRING_OBJECT_TOKENIZER_ASSERT_SVH
`define FLAT_JSON_STRING_OBJECT_TOKENIZER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FJSOT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FJSOT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fjsot_pkg.sv
// ----------------------------------------------------------------------------
// fjsot_pkg
// Types, character codes and helpers shared by the JSON tokenizer modules.
// ----------------------------------------------------------------------------
package fjsot_pkg;

    localparam logic [7:0] C_LBRACE    = 8'h7B;
    localparam logic [7:0] C_RBRACE    = 8'h7D;
    localparam logic [7:0] C_COLON     = 8'h3A;
    localparam logic [7:0] C_COMMA     = 8'h2C;
    localparam logic [7:0] C_QUOTE     = 8'h22;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_LOWER_N   = 8'h6E;
    localparam logic [7:0] C_LOWER_T   = 8'h74;
    localparam logic [7:0] C_LOWER_R   = 8'h72;
    localparam logic [7:0] C_SPACE     = 8'h20;
    localparam logic [7:0] C_TAB       = 8'h09;
    localparam logic [7:0] C_LF        = 8'h0A;
    localparam logic [7:0] C_CR        = 8'h0D;

    typedef enum logic [3:0] {
        PH_SEEK     = 4'd0,
        PH_OBJ      = 4'd1,
        PH_KEY      = 4'd2,
        PH_KEY_ESC  = 4'd3,
        PH_COLON    = 4'd4,
        PH_VALSTART = 4'd5,
        PH_VAL      = 4'd6,
        PH_VAL_ESC  = 4'd7,
        PH_AFTERVAL = 4'd8,
        PH_DONE     = 4'd9,
        PH_NOTOBJ   = 4'd10,
        PH_BAD      = 4'd11
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOTOBJ = 2'd1,
        ST_BAD    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_byte;
        logic       in_key;
        logic       string_end;
        logic       object_end;
        logic       status_valid;
        t_status    status;
    } t_out_item;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == C_SPACE) || ((c >= C_TAB) && (c <= C_CR));
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == C_LOWER_N) r = C_LF;
        else if (c == C_LOWER_T) r = C_TAB;
        else if (c == C_LOWER_R) r = C_CR;
        return r;
    endfunction

endpackage

>>> hw/rtl/fjsot_parser.sv
// ----------------------------------------------------------------------------
// fjsot_parser
// Phase register and per-byte transition logic; produces one result per item.
// ----------------------------------------------------------------------------
module fjsot_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  fjsot_pkg::t_in_item  i_item,
    output fjsot_pkg::t_out_item o_result,
    output fjsot_pkg::t_phase    o_phase
);

    fjsot_pkg::t_phase    r_phase;
    fjsot_pkg::t_phase    n_phase;
    fjsot_pkg::t_phase    w_ph;
    fjsot_pkg::t_out_item w_res;
    logic [7:0]           w_c;

    assign w_c = i_item.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fjsot_pkg::PH_SEEK;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        w_ph  = r_phase;
        w_res = '0;
        unique case (r_phase)
            fjsot_pkg::PH_SEEK: begin
                if (w_c == fjsot_pkg::C_LBRACE) w_ph = fjsot_pkg::PH_OBJ;
                else if (!fjsot_pkg::is_ws(w_c)) w_ph = fjsot_pkg::PH_NOTOBJ;
            end
            fjsot_pkg::PH_OBJ: begin
                if (w_c == fjsot_pkg::C_RBRACE) begin
                    w_ph             = fjsot_pkg::PH_DONE;
                    w_res.object_end = 1'b1;
                end else if (w_c == fjsot_pkg::C_QUOTE) begin
                    w_ph = fjsot_pkg::PH_KEY;
                end else if (!fjsot_pkg::is_ws(w_c)) begin
                    w_ph = fjsot_pkg::PH_BAD;
                end
            end
            fjsot_pkg::PH_KEY: begin
                w_res.in_key = 1'b1;
                if (w_c == fjsot_pkg::C_QUOTE) begin
                    w_res.string_end = 1'b1;
                    w_ph             = fjsot_pkg::PH_COLON;
                end else if (w_c == fjsot_pkg::C_BACKSLASH) begin
                    w_ph = fjsot_pkg::PH_KEY_ESC;
                end else begin
                    w_res.char_valid = 1'b1;
                    w_res.char_byte  = w_c;
                end
            end
            fjsot_pkg::PH_KEY_ESC: begin
                w_res.in_key     = 1'b1;
                w_res.char_valid = 1'b1;
                w_res.char_byte  = fjsot_pkg::unescape(w_c);
                w_ph             = fjsot_pkg::PH_KEY;
            end
            fjsot_pkg::PH_COLON: begin
                if (w_c == fjsot_pkg::C_COLON) w_ph = fjsot_pkg::PH_VALSTART;
                else if (!fjsot_pkg::is_ws(w_c)) w_ph = fjsot_pkg::PH_BAD;
            end
            fjsot_pkg::PH_VALSTART: begin
                if (w_c == fjsot_pkg::C_QUOTE) w_ph = fjsot_pkg::PH_VAL;
                else if (!fjsot_pkg::is_ws(w_c)) w_ph = fjsot_pkg::PH_BAD;
            end
            fjsot_pkg::PH_VAL: begin
                if (w_c == fjsot_pkg::C_QUOTE) begin
                    w_res.string_end = 1'b1;
                    w_ph             = fjsot_pkg::PH_AFTERVAL;
                end else if (w_c == fjsot_pkg::C_BACKSLASH) begin
                    w_ph = fjsot_pkg::PH_VAL_ESC;
                end else begin
                    w_res.char_valid = 1'b1;
                    w_res.char_byte  = w_c;
                end
            end
            fjsot_pkg::PH_VAL_ESC: begin
                w_res.char_valid = 1'b1;
                w_res.char_byte  = fjsot_pkg::unescape(w_c);
                w_ph             = fjsot_pkg::PH_VAL;
            end
            fjsot_pkg::PH_AFTERVAL: begin
                if (w_c == fjsot_pkg::C_COMMA) begin
                    w_ph = fjsot_pkg::PH_OBJ;
                end else if (w_c == fjsot_pkg::C_RBRACE) begin
                    w_ph             = fjsot_pkg::PH_DONE;
                    w_res.object_end = 1'b1;
                end else if (w_c == fjsot_pkg::C_QUOTE) begin
                    w_ph = fjsot_pkg::PH_KEY;
                end else if (!fjsot_pkg::is_ws(w_c)) begin
                    w_ph = fjsot_pkg::PH_BAD;
                end
            end
            fjsot_pkg::PH_DONE,
            fjsot_pkg::PH_NOTOBJ: begin
                w_ph = r_phase;
            end
            default: begin
                w_ph = fjsot_pkg::PH_BAD;
            end
        endcase

        n_phase = w_ph;
        if (i_item.is_last) begin
            w_res.status_valid = 1'b1;
            priority if (w_ph == fjsot_pkg::PH_SEEK || w_ph == fjsot_pkg::PH_NOTOBJ) begin
                w_res.status = fjsot_pkg::ST_NOTOBJ;
            end else if (w_ph == fjsot_pkg::PH_OBJ || w_ph == fjsot_pkg::PH_AFTERVAL
                         || w_ph == fjsot_pkg::PH_DONE) begin
                w_res.status = fjsot_pkg::ST_OK;
            end else begin
                w_res.status = fjsot_pkg::ST_BAD;
            end
            n_phase = fjsot_pkg::PH_SEEK;
        end
    end

    assign o_result = w_res;
    assign o_phase  = r_phase;

endmodule

>>> hw/rtl/fjsot_outbuf.sv
// ----------------------------------------------------------------------------
// fjsot_outbuf
// Result register plus skid register; input ready comes from a flop.
// ----------------------------------------------------------------------------
module fjsot_outbuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  fjsot_pkg::t_out_item i_result,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fjsot_pkg::t_out_item o_data
);

    logic                 r_out_valid;
    logic                 r_skid_valid;
    fjsot_pkg::t_out_item r_out;
    fjsot_pkg::t_out_item r_skid;
    logic                 n_out_valid;
    logic                 n_skid_valid;
    logic                 w_take;
    logic                 w_load_out;
    logic                 w_load_skid;
    logic                 w_pop_skid;

    assign w_take = r_out_valid & i_ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        w_load_out   = 1'b0;
        w_load_skid  = 1'b0;
        w_pop_skid   = 1'b0;
        if (w_take) begin
            if (r_skid_valid) begin
                w_pop_skid   = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_accept) begin
                w_load_out = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_accept) begin
            if (!r_out_valid) begin
                w_load_out  = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                w_load_skid  = 1'b1;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_skid) begin
            r_out <= r_skid;
        end else if (w_load_out) begin
            r_out <= i_result;
        end
        if (w_load_skid) begin
            r_skid <= i_result;
        end
    end

    assign o_space = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> hw/rtl/flat_json_string_object_tokenizer.sv
// ----------------------------------------------------------------------------
// flat_json_string_object_tokenizer
// Streaming tokenizer for one flat JSON object of string keys and values.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+---------------------------
//   input    | in  | i_valid / o_ready  | i_data (fjsot_pkg::t_in_item)
//   result   | out | o_valid / i_ready  | o_data (fjsot_pkg::t_out_item)
//
// One byte per cycle while o_ready is high; each accepted item yields one registered result.
// The per-byte phase transition closes its loop through the phase register alone.
// A two-entry result buffer keeps o_ready high while one result waits.
// o_ready drops only when both result entries are full.
// Synchronous active-low reset returns the phase to seeking the opening brace.
// ----------------------------------------------------------------------------
`include "flat_json_string_object_tokenizer_assert.svh"

module flat_json_string_object_tokenizer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fjsot_pkg::t_in_item  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fjsot_pkg::t_out_item o_data
);

    logic                 w_accept;
    fjsot_pkg::t_out_item w_result;
    fjsot_pkg::t_phase    w_phase;

    assign w_accept = i_valid & o_ready;

    fjsot_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_data),
        .o_result (w_result),
        .o_phase  (w_phase)
    );

    fjsot_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_result (w_result),
        .o_space  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_data   (o_data)
    );

    `FJSOT_ASSERT_NEXT(a_last_resets_phase, w_accept && i_data.is_last, w_phase == fjsot_pkg::PH_SEEK, "phase not back to seek after last byte")
    `FJSOT_ASSERT_NOW(a_stall_means_full, !o_ready, o_valid, "input stalled with empty result register")
    `FJSOT_ASSERT_NOW(a_status_only_last, o_valid && !o_data.status_valid, o_data.status == fjsot_pkg::ST_OK, "status set without status_valid")
    `FJSOT_ASSERT_NOW(a_char_not_end, o_valid && o_data.char_valid, !o_data.string_end && !o_data.object_end, "character and end flag together")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flat JSON object tokenizer. Byte streams go in
// over a valid/ready channel; a predictor follows the parse phase per byte and
// queues the expected token item, which is checked field by field against
// every item taken from the result channel. Directed texts cover every phase
// and status; random objects, broken and noisy, run under several idle mixes.
// ----------------------------------------------------------------------------
module tb;
    import fjsot_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_PRINTED = 40;
    localparam logic [7:0] C_VT = 8'h0B;
    localparam logic [7:0] C_FF = 8'h0C;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_data = '0;
    logic      i_ready = 1'b0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_data;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int err_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int texts_sent = 0;
    int tokens_seen = 0;
    int chars_seen = 0;
    int ends_seen = 0;
    int objects_seen = 0;
    int ok_seen = 0;
    int notobj_seen = 0;
    int bad_seen = 0;

    t_phase     tok_phase = PH_SEEK;
    t_out_item  expected_tokens [$];
    logic [7:0] text_buf [$];

    flat_json_string_object_tokenizer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_tokens.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic is_blank(input logic [7:0] c);
        return (c == C_SPACE) || (c inside {[C_TAB:C_CR]});
    endfunction

    function automatic logic [7:0] decode_escape(input logic [7:0] c);
        case (c)
            C_LOWER_N: return C_LF;
            C_LOWER_T: return C_TAB;
            C_LOWER_R: return C_CR;
            default:   return c;
        endcase
    endfunction

    // advances tok_phase by one byte and returns the token item it yields
    function automatic t_out_item predict_token(input t_in_item it);
        t_out_item  r;
        t_phase     nxt;
        logic [7:0] c;
        r = '0;
        c = it.data_byte;
        nxt = tok_phase;
        case (tok_phase)
            PH_SEEK: begin
                if (c == C_LBRACE) nxt = PH_OBJ;
                else if (!is_blank(c)) nxt = PH_NOTOBJ;
            end
            PH_OBJ: begin
                if (c == C_RBRACE) begin
                    nxt = PH_DONE;
                    r.object_end = 1'b1;
                end else if (c == C_QUOTE) nxt = PH_KEY;
                else if (!is_blank(c)) nxt = PH_BAD;
            end
            PH_KEY: begin
                r.in_key = 1'b1;
                if (c == C_QUOTE) begin
                    r.string_end = 1'b1;
                    nxt = PH_COLON;
                end else if (c == C_BACKSLASH) nxt = PH_KEY_ESC;
                else begin
                    r.char_valid = 1'b1;
                    r.char_byte = c;
                end
            end
            PH_KEY_ESC: begin
                r.in_key = 1'b1;
                r.char_valid = 1'b1;
                r.char_byte = decode_escape(c);
                nxt = PH_KEY;
            end
            PH_COLON: begin
                if (c == C_COLON) nxt = PH_VALSTART;
                else if (!is_blank(c)) nxt = PH_BAD;
            end
            PH_VALSTART: begin
                if (c == C_QUOTE) nxt = PH_VAL;
                else if (!is_blank(c)) nxt = PH_BAD;
            end
            PH_VAL: begin
                if (c == C_QUOTE) begin
                    r.string_end = 1'b1;
                    nxt = PH_AFTERVAL;
                end else if (c == C_BACKSLASH) nxt = PH_VAL_ESC;
                else begin
                    r.char_valid = 1'b1;
                    r.char_byte = c;
                end
            end
            PH_VAL_ESC: begin
                r.char_valid = 1'b1;
                r.char_byte = decode_escape(c);
                nxt = PH_VAL;
            end
            PH_AFTERVAL: begin
                if (c == C_COMMA) nxt = PH_OBJ;
                else if (c == C_RBRACE) begin
                    nxt = PH_DONE;
                    r.object_end = 1'b1;
                end else if (c == C_QUOTE) nxt = PH_KEY;
                else if (!is_blank(c)) nxt = PH_BAD;
            end
            PH_DONE, PH_NOTOBJ: ;
            default: nxt = PH_BAD;
        endcase
        if (it.is_last) begin
            r.status_valid = 1'b1;
            case (nxt)
                PH_SEEK, PH_NOTOBJ:           r.status = ST_NOTOBJ;
                PH_OBJ, PH_AFTERVAL, PH_DONE: r.status = ST_OK;
                default:                      r.status = ST_BAD;
            endcase
            nxt = PH_SEEK;
        end
        tok_phase = nxt;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < MAX_PRINTED)
            $display("ERROR cycle %0d result %0d: %s", cycle_count, tokens_seen, what);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_tokens
        t_out_item exp_tok;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("result with no byte pending");
            end else begin
                exp_tok = expected_tokens.pop_front();
                if (o_data.char_valid !== exp_tok.char_valid)
                    report_mismatch($sformatf("char_valid %0b, want %0b",
                                              o_data.char_valid, exp_tok.char_valid));
                if (o_data.char_byte !== exp_tok.char_byte)
                    report_mismatch($sformatf("char_byte %h, want %h",
                                              o_data.char_byte, exp_tok.char_byte));
                if (o_data.in_key !== exp_tok.in_key)
                    report_mismatch($sformatf("in_key %0b, want %0b",
                                              o_data.in_key, exp_tok.in_key));
                if (o_data.string_end !== exp_tok.string_end)
                    report_mismatch($sformatf("string_end %0b, want %0b",
                                              o_data.string_end, exp_tok.string_end));
                if (o_data.object_end !== exp_tok.object_end)
                    report_mismatch($sformatf("object_end %0b, want %0b",
                                              o_data.object_end, exp_tok.object_end));
                if (o_data.status_valid !== exp_tok.status_valid)
                    report_mismatch($sformatf("status_valid %0b, want %0b",
                                              o_data.status_valid, exp_tok.status_valid));
                if (o_data.status !== exp_tok.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_data.status, exp_tok.status));
                if (exp_tok.char_valid) chars_seen++;
                if (exp_tok.string_end) ends_seen++;
                if (exp_tok.object_end) objects_seen++;
                if (exp_tok.status_valid) begin
                    case (exp_tok.status)
                        ST_OK:     ok_seen++;
                        ST_NOTOBJ: notobj_seen++;
                        default:   bad_seen++;
                    endcase
                end
            end
            tokens_seen++;
        end
    end

    // entered at a rising edge; returns at the edge where the item is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in_item it;
        it.data_byte = b;
        it.is_last = last;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_tokens.push_back(predict_token(it));
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
        texts_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic send_str(input string s);
        add_str(s);
        send_text();
    endtask

    task automatic add_blank(input int n);
        repeat (n) begin
            case ($urandom_range(5))
                0: text_buf.push_back(C_SPACE);
                1: text_buf.push_back(C_TAB);
                2: text_buf.push_back(C_LF);
                3: text_buf.push_back(C_VT);
                4: text_buf.push_back(C_FF);
                default: text_buf.push_back(C_CR);
            endcase
        end
    endtask

    task automatic add_string();
        logic [7:0] b;
        text_buf.push_back(C_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(5) == 0) begin
                text_buf.push_back(C_BACKSLASH);
                case ($urandom_range(5))
                    0: b = C_QUOTE;
                    1: b = C_BACKSLASH;
                    2: b = C_LOWER_N;
                    3: b = C_LOWER_T;
                    4: b = C_LOWER_R;
                    default: b = 8'($urandom_range(255));
                endcase
            end else begin
                do b = 8'($urandom_range(255)); while (b == C_QUOTE || b == C_BACKSLASH);
            end
            text_buf.push_back(b);
        end
        text_buf.push_back(C_QUOTE);
    endtask

    // mostly well-formed objects; some cut short, corrupted, or plain noise
    task automatic build_random_text();
        int kind;
        int npairs;
        int cut;
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(255)));
            if ($urandom_range(1)) text_buf[0] = C_LBRACE;
        end else begin
            add_blank($urandom_range(0, 2));
            text_buf.push_back(C_LBRACE);
            npairs = $urandom_range(0, 4);
            for (int p = 0; p < npairs; p++) begin
                add_blank($urandom_range(0, 1));
                add_string();
                add_blank($urandom_range(0, 1));
                text_buf.push_back(C_COLON);
                add_blank($urandom_range(0, 1));
                add_string();
                add_blank($urandom_range(0, 1));
                if ($urandom_range(3) != 0) text_buf.push_back(C_COMMA);
            end
            add_blank($urandom_range(0, 1));
            if ($urandom_range(9) != 0) text_buf.push_back(C_RBRACE);
            repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(255)));
            if (kind < 25) begin
                cut = $urandom_range(1, text_buf.size());
                while (text_buf.size() > cut) void'(text_buf.pop_back());
            end else if (kind < 35) begin
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(255));
            end
        end
    endtask

    task automatic test_well_formed();
        send_str("{\"k\":\"v\"}");
        text_buf.push_back(C_SPACE);
        text_buf.push_back(C_TAB);
        text_buf.push_back(C_LF);
        text_buf.push_back(C_VT);
        text_buf.push_back(C_FF);
        text_buf.push_back(C_CR);
        add_str("{ \"a\\\"\\\\\\n\\t\\r\\q\" : \"\\\"\\\\\\n\\t\\r\\z\" , \"\":\"\" ,}tail");
        send_text();
        send_str("{\"a\":\"b\"\"c\":\"d\",}");
    endtask

    task automatic test_byte_extremes();
        add_str("{\"");
        text_buf.push_back(8'h00);
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h80);
        text_buf.push_back(C_BACKSLASH);
        text_buf.push_back(8'hFF);
        text_buf.push_back(C_BACKSLASH);
        text_buf.push_back(8'h00);
        add_str("\":\"");
        text_buf.push_back(8'hFF);
        text_buf.push_back(8'h01);
        add_str("\"}");
        text_buf.push_back(8'hFF);
        send_text();
    endtask

    task automatic test_not_object();
        send_str("  x{}");
        add_blank(6);
        send_text();
        text_buf.push_back(8'h80);
        add_str("{}");
        send_text();
    endtask

    task automatic test_malformed();
        send_str("{x");
        send_str("{\"a\" x");
        send_str("{\"a\"}");
        send_str("{\"a\":x");
        send_str("{\"a\":\"b\" x");
    endtask

    task automatic test_unterminated();
        send_str("{\"ab");
        send_str("{\"a\\");
        send_str("{\"a\"");
        send_str("{\"a\":");
        send_str("{\"a\":\"b");
        send_str("{\"a\":\"b\\");
    endtask

    task automatic test_open_object();
        send_str("{");
        send_str("{\"a\":\"b\"  \n");
        send_str("{\"a\":\"b\",");
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int nbytes);
        int stop_at;
        src_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at) begin
            build_random_text();
            send_text();
            if ($urandom_range(19) == 0) wait_idle();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_well_formed();
        test_byte_extremes();
        test_not_object();
        test_malformed();
        test_unterminated();
        test_open_object();
        wait_idle();
        test_random(0, 0, 175);
        test_random(80, 0, 175);
        wait_idle();
        test_random(0, 80, 175);
        test_random(32, 32, 175);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes in %0d texts; checked %0d items: %0d chars, %0d string ends",
                 bytes_sent, texts_sent, tokens_seen, chars_seen, ends_seen);
        $display("Closed objects %0d; status ok %0d, not an object %0d, malformed %0d",
                 objects_seen, ok_seen, notobj_seen, bad_seen);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", err_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
